// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the playback watchdog checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASPW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold on every clock edge outside reset
`define ASPW_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// File: rtl/core/aspw_pkg.sv
// ----------------------------------------------------------------------------
// aspw_pkg
// shared widths, codes and the frame classifier of the playback watchdog
// ----------------------------------------------------------------------------
package aspw_pkg;

  localparam int PosW     = 32;
  localparam int LenW     = 16;
  localparam int CauseW   = 2;
  localparam int ClassW   = 3;
  localparam int CfgIdxW  = 8;
  localparam int InDataW  = 24;
  localparam int OutDataW = 8;
  localparam int CntW     = 5;

  localparam logic [CauseW-1:0] CAUSE_NONE   = 2'd0;
  localparam logic [CauseW-1:0] CAUSE_CHOPPY = 2'd1;
  localparam logic [CauseW-1:0] CAUSE_BLANK  = 2'd2;

  localparam logic [ClassW-1:0] CLS_NORMAL      = 3'd0;
  localparam logic [ClassW-1:0] CLS_WARM_BLANK  = 3'd1;
  localparam logic [ClassW-1:0] CLS_WARM_BLANK_D = 3'd2;
  localparam logic [ClassW-1:0] CLS_BLANK       = 3'd3;
  localparam logic [ClassW-1:0] CLS_BLANK_D     = 3'd4;
  localparam logic [ClassW-1:0] CLS_GAPS        = 3'd5;
  localparam logic [ClassW-1:0] CLS_GAPS_D      = 3'd6;
  localparam logic [ClassW-1:0] CLS_DROPS       = 3'd7;

  localparam logic [CfgIdxW-1:0] REG_BLANK_LIMIT  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_CHOPPY_LIMIT = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_LEN   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_WARMUP_LEN   = 8'd3;

  typedef logic [PosW-1:0] pos_t;

  function automatic logic [ClassW-1:0] classify(input logic sig, input logic gaps,
                                                 input logic drops, input logic warm);
    logic [ClassW-1:0] c;
    if (!sig) begin
      if (warm) c = drops ? CLS_WARM_BLANK_D : CLS_WARM_BLANK;
      else      c = drops ? CLS_BLANK_D : CLS_BLANK;
    end else if (gaps) begin
      c = drops ? CLS_GAPS_D : CLS_GAPS;
    end else if (drops) begin
      c = CLS_DROPS;
    end else begin
      c = CLS_NORMAL;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/audio_stream_playback_watchdog_top.sv
// ----------------------------------------------------------------------------
// audio_stream_playback_watchdog_top
// frame watchdog: read position tracking, choppy and blank timeouts, status
// ----------------------------------------------------------------------------
// Each accepted frame gives its result after the states S_DIV1, S_END, S_DIV2,
// S_CMP and S_FIN, and in_tready stays low throughout (longer while an earlier result is
// still stalled in the output register): one shared restoring remainder unit
// (one 32-bit compare and subtract per cycle) runs twice for 32 steps each,
// first on the read position to find the window start, then on the new
// position for window alignment, with bookkeeping in S_END, S_CMP and S_FIN. The result
// sits in an output register, so a stalled result does not block the next
// frame until that frame is finished.
// Configuration writes are taken at any time but belong between frames;
// writing the warmup register restarts all positions.
module audio_stream_playback_watchdog_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frame_samples[15:0], has_signal[16], has_gaps[17], has_drops[18], zero pad
  input  logic [aspw_pkg::InDataW-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // abort[0], abort_cause[2:1], frame_class[5:3], zero pad
  output logic [aspw_pkg::OutDataW-1:0]     out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aspw_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [aspw_pkg::PosW-1:0]         cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_END  = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [aspw_pkg::CntW-1:0] CNT_LAST = aspw_pkg::CntW'(aspw_pkg::PosW - 1);

  logic [2:0]                    state_r;
  logic [aspw_pkg::CntW-1:0]     cnt_r;
  aspw_pkg::pos_t                blank_r, choppy_r, win_len_r, warmup_r;
  aspw_pkg::pos_t                rp_r, lsp_r, lgw_r;
  logic [1:0]                    wf_r;
  logic                          warm_r;
  aspw_pkg::pos_t                next_r, dvd_r, rem_r, end_r;
  logic                          sig_r, gaps_r, drops_r;
  logic                          le_r, r2z_r;
  logic                          out_valid_r;
  logic                          abort_r;
  logic [aspw_pkg::CauseW-1:0]   cause_r;
  logic [aspw_pkg::ClassW-1:0]   class_r;

  aspw_pkg::pos_t                win;
  logic [aspw_pkg::PosW:0]       rem_sh;
  aspw_pkg::pos_t                rem_step;
  aspw_pkg::pos_t                end_diff;
  logic                          in_acc;
  logic                          commit;

  // finish stage values
  logic                          sig_upd, warm1, choppy_hit, blank_hit, warm_nxt;
  logic [1:0]                    ff, flags_or, wf_nxt;
  aspw_pkg::pos_t                lsp_nxt, lgw_nxt;
  logic [aspw_pkg::CauseW-1:0]   cause_nxt;

  assign win      = (win_len_r == '0) ? aspw_pkg::PosW'(1) : win_len_r;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc   = in_tvalid && in_tready;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // shared remainder step
  always_comb begin
    rem_sh   = {rem_r, dvd_r[aspw_pkg::PosW-1]};
    rem_step = (rem_sh >= {1'b0, win}) ? aspw_pkg::PosW'(rem_sh - {1'b0, win})
                                       : rem_sh[aspw_pkg::PosW-1:0];
    end_diff = end_r - next_r;
  end

  always_comb begin
    ff       = {drops_r, gaps_r};
    sig_upd  = (blank_r != '0) && sig_r;
    warm1    = sig_upd ? 1'b0 : warm_r;
    lsp_nxt  = sig_upd ? next_r : lsp_r;
    flags_or = wf_r | ff;
    lgw_nxt  = lgw_r;
    wf_nxt   = wf_r;
    if (choppy_r != '0) begin
      wf_nxt = flags_or;
      if (le_r) begin
        if (flags_or != 2'b11) lgw_nxt = next_r;
        wf_nxt = r2z_r ? 2'b00 : ff;
      end
    end
    choppy_hit = (choppy_r != '0) && ((next_r - lgw_nxt) >= choppy_r);
    blank_hit  = (blank_r != '0) && !warm1 && ((next_r - lsp_nxt) >= blank_r);
    if (choppy_hit) begin
      cause_nxt = aspw_pkg::CAUSE_CHOPPY;
      warm_nxt  = warm1;
    end else if (blank_hit) begin
      cause_nxt = aspw_pkg::CAUSE_BLANK;
      warm_nxt  = warm1;
    end else begin
      cause_nxt = aspw_pkg::CAUSE_NONE;
      warm_nxt  = warm1 && (next_r < warmup_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      blank_r     <= '0;
      choppy_r    <= '0;
      win_len_r   <= aspw_pkg::PosW'(1);
      warmup_r    <= '0;
      rp_r        <= '0;
      lsp_r       <= '0;
      lgw_r       <= '0;
      wf_r        <= '0;
      warm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            next_r  <= rp_r + aspw_pkg::PosW'(in_tdata[aspw_pkg::LenW-1:0]);
            sig_r   <= in_tdata[aspw_pkg::LenW];
            gaps_r  <= in_tdata[aspw_pkg::LenW+1];
            drops_r <= in_tdata[aspw_pkg::LenW+2];
            dvd_r   <= rp_r;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          rem_r <= rem_step;
          dvd_r <= {dvd_r[aspw_pkg::PosW-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) state_r <= (state_r == S_DIV1) ? S_END : S_CMP;
        end
        S_END: begin
          // end of the aligned window holding the old position
          end_r   <= rp_r - rem_r + win;
          dvd_r   <= next_r;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV2;
        end
        S_CMP: begin
          le_r    <= (end_diff == '0) || end_diff[aspw_pkg::PosW-1];
          r2z_r   <= (rem_r == '0);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (commit) begin
            rp_r    <= next_r;
            lsp_r   <= lsp_nxt;
            lgw_r   <= lgw_nxt;
            wf_r    <= wf_nxt;
            warm_r  <= warm_nxt;
            abort_r <= (cause_nxt != aspw_pkg::CAUSE_NONE);
            cause_r <= cause_nxt;
            class_r <= aspw_pkg::classify(sig_r, gaps_r, drops_r, warm1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (commit)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aspw_pkg::REG_BLANK_LIMIT:  blank_r   <= cfg_data;
          aspw_pkg::REG_CHOPPY_LIMIT: choppy_r  <= cfg_data;
          aspw_pkg::REG_WINDOW_LEN:   win_len_r <= cfg_data;
          aspw_pkg::REG_WARMUP_LEN: begin
            warmup_r <= cfg_data;
            rp_r     <= '0;
            lsp_r    <= cfg_data;
            lgw_r    <= '0;
            wf_r     <= '0;
            warm_r   <= (cfg_data != '0);
          end
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, class_r, cause_r, abort_r};

endmodule

// File: rtl/core/aspw_checker.sv
// ----------------------------------------------------------------------------
// aspw_checker
// port level checks of the playback watchdog, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aspw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [aspw_pkg::OutDataW-1:0] out_tdata
);

  logic [aspw_pkg::CauseW-1:0] cause;
  logic                        cause_ok;

  assign cause    = out_tdata[aspw_pkg::CauseW:1];
  assign cause_ok = (cause == aspw_pkg::CAUSE_NONE) || (cause == aspw_pkg::CAUSE_CHOPPY) ||
                    (cause == aspw_pkg::CAUSE_BLANK);

  // held word stays offered
  `ASPW_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result word dropped")
  `ASPW_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")
  // abort flag agrees with its cause
  `ASPW_ASSERT_ALWAYS(a_abort_cause, !out_tvalid || (out_tdata[0] == (cause != 2'd0)), "abort")
  `ASPW_ASSERT_ALWAYS(a_cause_code, !out_tvalid || cause_ok, "undefined abort cause")
  // one frame at a time through the remainder unit
  `ASPW_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accept while busy")

endmodule

bind audio_stream_playback_watchdog_top aspw_checker u_aspw_checker (.*);

// File: verif/aspw_frame_checker.sv
// ----------------------------------------------------------------------------
// aspw_frame_checker
// watches the frame, status and register channels of the playback watchdog,
// predicts the status word of every accepted frame and compares it field by
// field with the word the block returns
// ----------------------------------------------------------------------------
module aspw_frame_checker
  import aspw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [PosW-1:0]     cfg_data,
  output int unsigned         mismatches,
  output int unsigned         pending,
  output int unsigned         frames_seen,
  output int unsigned         writes_seen,
  output int unsigned         choppy_aborts,
  output int unsigned         blank_aborts
);

  localparam logic [1:0] BAD_WINDOW = 2'b11;

  typedef struct packed {
    logic              abort;
    logic [CauseW-1:0] cause;
    logic [ClassW-1:0] cls;
  } frame_status_t;

  frame_status_t expected_status_q[$];

  pos_t       blank_lim, choppy_lim, win_len, warmup_len;
  pos_t       rd_pos, sig_pos, good_pos;
  logic [1:0] win_flags;
  logic       warming;

  function automatic void restart_tracking();
    rd_pos    = '0;
    sig_pos   = warmup_len;
    good_pos  = '0;
    win_flags = '0;
    warming   = (warmup_len != 0);
  endfunction

  function automatic void write_register(input logic [CfgIdxW-1:0] idx, input pos_t val);
    case (idx)
      REG_BLANK_LIMIT:  blank_lim = val;
      REG_CHOPPY_LIMIT: choppy_lim = val;
      REG_WINDOW_LEN:   win_len = val;
      REG_WARMUP_LEN: begin
        warmup_len = val;
        restart_tracking();
      end
      default: ;
    endcase
  endfunction

  function automatic frame_status_t predict_status(input logic [LenW-1:0] len,
                                                   input logic sig, input logic gaps,
                                                   input logic drops);
    frame_status_t st;
    pos_t          nxt, win, wstart, wend, diff, since;
    logic [1:0]    fflags;
    fflags = {drops, gaps};
    nxt    = rd_pos + pos_t'(len);
    win    = (win_len == 0) ? pos_t'(1) : win_len;
    st.abort = 1'b0;
    st.cause = CAUSE_NONE;

    if (blank_lim != 0 && sig) begin
      sig_pos = nxt;
      warming = 1'b0;
    end

    if (choppy_lim != 0) begin
      win_flags = win_flags | fflags;
      wstart    = (rd_pos / win) * win;
      wend      = wstart + win;
      diff      = wend - nxt;
      // window closed when its end is at or before the new position
      if (diff == 0 || diff[PosW-1]) begin
        if (win_flags != BAD_WINDOW) good_pos = nxt;
        win_flags = ((nxt % win) == 0) ? 2'b00 : fflags;
      end
    end

    if (!sig) begin
      if (warming) st.cls = drops ? CLS_WARM_BLANK_D : CLS_WARM_BLANK;
      else         st.cls = drops ? CLS_BLANK_D : CLS_BLANK;
    end else if (gaps) begin
      st.cls = drops ? CLS_GAPS_D : CLS_GAPS;
    end else if (drops) begin
      st.cls = CLS_DROPS;
    end else begin
      st.cls = CLS_NORMAL;
    end

    rd_pos = nxt;
    diff   = rd_pos - good_pos;
    since  = rd_pos - sig_pos;
    if (choppy_lim != 0 && diff >= choppy_lim) begin
      st.abort = 1'b1;
      st.cause = CAUSE_CHOPPY;
    end else if (blank_lim != 0 && !warming && since >= blank_lim) begin
      st.abort = 1'b1;
      st.cause = CAUSE_BLANK;
    end else begin
      warming = warming && (rd_pos < warmup_len);
    end
    return st;
  endfunction

  always @(posedge clk) begin
    frame_status_t exp_st, got_st;
    int unsigned   errs;
    errs = 0;
    if (!rst_n) begin
      blank_lim  = '0;
      choppy_lim = '0;
      win_len    = pos_t'(1);
      warmup_len = '0;
      restart_tracking();
      expected_status_q.delete();
      mismatches    <= 0;
      frames_seen   <= 0;
      writes_seen   <= 0;
      choppy_aborts <= 0;
      blank_aborts  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_data);
        writes_seen <= writes_seen + 1;
      end
      if (in_tvalid && in_tready) begin
        exp_st = predict_status(in_tdata[LenW-1:0], in_tdata[16], in_tdata[17],
                                in_tdata[18]);
        expected_status_q.push_back(exp_st);
        frames_seen <= frames_seen + 1;
        if (exp_st.cause == CAUSE_CHOPPY) choppy_aborts <= choppy_aborts + 1;
        if (exp_st.cause == CAUSE_BLANK) blank_aborts <= blank_aborts + 1;
      end
      if (out_tvalid && out_tready) begin
        got_st.abort = out_tdata[0];
        got_st.cause = out_tdata[2:1];
        got_st.cls   = out_tdata[5:3];
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected status word, expected none got %h", $time, out_tdata);
          errs++;
        end else begin
          exp_st = expected_status_q.pop_front();
          if (got_st.abort !== exp_st.abort) begin
            $display("%0t: abort expected %0d got %0d", $time, exp_st.abort, got_st.abort);
            errs++;
          end
          if (got_st.cause !== exp_st.cause) begin
            $display("%0t: abort_cause expected %0d got %0d", $time, exp_st.cause,
                     got_st.cause);
            errs++;
          end
          if (got_st.cls !== exp_st.cls) begin
            $display("%0t: frame_class expected %0d got %0d", $time, exp_st.cls,
                     got_st.cls);
            errs++;
          end
        end
      end
      if (errs != 0) mismatches <= mismatches + errs;
    end
    pending <= expected_status_q.size();
  end

endmodule

// File: verif/tb_audio_stream_playback_watchdog_top.sv
// ----------------------------------------------------------------------------
// tb_audio_stream_playback_watchdog_top
// drives frames and register writes into the playback watchdog: a directed
// pass over every frame class, both timeouts, warmup and window corners, then
// randomized phases of healthy, choppy and silent bursts under random
// register settings and random stalls on both streams
// ----------------------------------------------------------------------------
module tb_audio_stream_playback_watchdog_top;
  import aspw_pkg::*;

  localparam int          IdleLimit   = 4000;
  localparam int          DrainCycles = 80;
  localparam int          FrameTarget = 850;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 8'hFF;

  typedef enum logic [1:0] {BURST_GOOD, BURST_CHOPPY, BURST_SILENT, BURST_NOISE} burst_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [PosW-1:0]     cfg_data;

  int unsigned mismatches, pending, frames_seen, writes_seen;
  int unsigned choppy_aborts, blank_aborts;
  int unsigned frames_sent;
  int unsigned idle_cycles = 0;
  logic        quiet;

  audio_stream_playback_watchdog_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  aspw_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .frames_seen   (frames_seen),
    .writes_seen   (writes_seen),
    .choppy_aborts (choppy_aborts),
    .blank_aborts  (blank_aborts)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(0, 99) >= 30);
  end

  // no word on any channel for too long means the block hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles, %0d status words outstanding",
               idle_cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_frame(input logic [LenW-1:0] len, input logic sig,
                            input logic gaps, input logic drops);
    int unsigned gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 30) gap++;
      if ($urandom_range(0, 19) == 0) gap += $urandom_range(40, 120);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, drops, gaps, sig, len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frames_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input pos_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // called right after a frame handshake: let every status word come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic pos_t pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic pos_t pick_window();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return pos_t'(1);
      2:       return '1;
      3:       return $urandom;
      default: return $urandom_range(2, 400);
    endcase
  endfunction

  function automatic pos_t pick_warmup();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      3:       return $urandom;
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  function automatic logic [LenW-1:0] pick_length();
    case ($urandom_range(0, 15))
      0:       return LenW'($urandom_range(0, 65535));
      1:       return '0;
      2:       return '1;
      default: return LenW'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic send_burst(input burst_t kind, input int unsigned count);
    logic sig, gaps, drops;
    repeat (count) begin
      case (kind)
        BURST_GOOD: begin
          sig   = 1'b1;
          gaps  = ($urandom_range(0, 9) == 0);
          drops = ($urandom_range(0, 9) == 0);
        end
        BURST_CHOPPY: begin
          sig   = 1'($urandom_range(0, 1));
          gaps  = ($urandom_range(0, 9) != 0);
          drops = ($urandom_range(0, 9) != 0);
        end
        BURST_SILENT: begin
          sig   = ($urandom_range(0, 19) == 0);
          gaps  = 1'($urandom_range(0, 1));
          drops = 1'($urandom_range(0, 1));
        end
        default: begin
          sig   = 1'($urandom_range(0, 1));
          gaps  = 1'($urandom_range(0, 1));
          drops = 1'($urandom_range(0, 1));
        end
      endcase
      send_frame(pick_length(), sig, gaps, drops);
    end
  endtask

  initial begin
    int unsigned phase, budget, burst_len;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    quiet        = 1'b0;
    frames_sent  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: both checks off, four flag combinations with extreme and small lengths
    send_frame(16'd0, 1'b0, 1'b0, 1'b0);
    send_frame(16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_frame(16'd1, 1'b1, 1'b0, 1'b1);
    send_frame(16'd2, 1'b0, 1'b1, 1'b0);
    drain();

    write_reg(REG_BLANK_LIMIT, 32'd300);
    write_reg(REG_CHOPPY_LIMIT, 32'd400);
    write_reg(REG_WINDOW_LEN, 32'd100);
    write_reg(REG_WARMUP_LEN, 32'd200);
    // warm blank frames, end of warmup, then a blank timeout
    send_frame(16'd60, 1'b0, 1'b0, 1'b0);
    send_frame(16'd60, 1'b0, 1'b0, 1'b1);
    send_frame(16'd100, 1'b0, 1'b1, 1'b1);
    send_frame(16'd100, 1'b0, 1'b0, 1'b0);
    send_frame(16'd200, 1'b0, 1'b0, 1'b1);
    // signal classes, then bad windows until the choppy timeout
    send_frame(16'd10, 1'b1, 1'b0, 1'b0);
    send_frame(16'd50, 1'b1, 1'b1, 1'b0);
    send_frame(16'd50, 1'b1, 1'b1, 1'b1);
    send_frame(16'd50, 1'b1, 1'b0, 1'b1);
    repeat (5) send_frame(16'd100, 1'b1, 1'b1, 1'b1);
    drain();

    // zero window length, window longer than the choppy limit, ignored index
    write_reg(REG_WINDOW_LEN, 32'd0);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    send_frame(16'd3, 1'b1, 1'b1, 1'b1);
    send_frame(16'd0, 1'b1, 1'b1, 1'b1);
    drain();
    write_reg(REG_CHOPPY_LIMIT, 32'd50);
    write_reg(REG_WINDOW_LEN, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'd7);
    send_frame(16'd60, 1'b1, 1'b1, 1'b1);
    send_frame(16'd60, 1'b0, 1'b1, 1'b1);
    drain();

    phase = 0;
    while (frames_sent < FrameTarget) begin
      quiet = (phase == 4);
      if ($urandom_range(0, 1)) write_reg(REG_BLANK_LIMIT, pick_limit());
      if ($urandom_range(0, 1)) write_reg(REG_CHOPPY_LIMIT, pick_limit());
      if ($urandom_range(0, 1)) write_reg(REG_WINDOW_LEN, pick_window());
      if ($urandom_range(0, 7) == 0)
        write_reg(CfgIdxW'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
      if ($urandom_range(0, 2) == 0) write_reg(REG_WARMUP_LEN, pick_warmup());
      budget = $urandom_range(25, 55);
      if (budget > FrameTarget - frames_sent) budget = FrameTarget - frames_sent;
      while (budget != 0) begin
        burst_len = $urandom_range(1, 20);
        if (burst_len > budget) burst_len = budget;
        send_burst(burst_t'($urandom_range(0, 3)), burst_len);
        budget -= burst_len;
      end
      drain();
      phase++;
    end

    quiet = 1'b0;
    repeat (DrainCycles) @(posedge clk);
    $display("ran %0d frames over %0d random phases with %0d register writes",
             frames_seen, phase, writes_seen);
    $display("predicted %0d choppy and %0d blank timeouts", choppy_aborts, blank_aborts);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
